// File: design/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants for the byte pattern scan core
// Register indexes, cell handoff structs, the result word and case folding.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned PAT_W      = 128;  // sixteen configured pattern bytes

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_HIGH = 3'd1,
    CFG_PAT_LEN  = 3'd2,
    CFG_IGN_CASE = 3'd3,
    CFG_BASE     = 3'd4
  } cfg_idx_e;

  // Controls broadcast to every window cell.
  typedef struct packed {
    logic shift;   // a word was accepted
    logic clear;   // that word ends the region
    logic fold;    // compare case-insensitively
  } cell_ctrl_t;

  // What one cell hands to its neighbor.
  typedef struct packed {
    logic       held;
    logic [7:0] data;
  } cell_data_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic              done;
  } res_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic upper;
    upper = (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z);
    return (en && upper) ? c + CASE_OFFSET : c;
  endfunction

endpackage

// File: design/byte_pattern_scan_core.sv
// ----------------------------------------------------------------------------
// byte_pattern_scan_core: streaming pattern search over a byte region
// Reports every occurrence, overlaps included, of a 1 to 16 byte pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one region byte per word,
//   with region_end_i marking the last byte. Output channel (out_valid_o /
//   out_stall_i) carries a word only when a match completes on a byte or the
//   byte ends the region: found_o with the match start address, scan_done_o.
//   A match address is base_address plus the offset of the match's first byte.
//   Throughput is one byte per cycle while in_stall_o is low, set by the
//   window cell row, which shifts and compares every position in parallel
//   in the accepting cycle. A registered result shows up on the output in
//   the cycle after acceptance while the output register is free or draining.
//   The output side has a result register plus one skid word; input stalls
//   only while that skid word is occupied, so a stall on the output reaches
//   the input once the skid word fills. A one-cycle output stall that lands
//   on a held result with a second one behind it stalls input as the skid drains.
//   Reset empties the window, zeroes the offset, clears pending results and
//   loads the register defaults (pattern length 1, others 0). The window
//   and offset clear again after each region's final byte.
//   Program registers through cfg_we_i / cfg_index_i / cfg_data_i only while
//   no result is outstanding; new values apply to the next accepted byte.
// ----------------------------------------------------------------------------
module byte_pattern_scan_core #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           region_end_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [bps_pkg::ADDR_W-1:0]     match_address_o,
  output logic                           scan_done_o
);
  import bps_pkg::*;

  localparam logic [6:0] MAX_LEN = 7'(MAX_PATTERN);

  // Configuration registers
  logic [PAT_W-1:0]  pattern_q, pattern_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ign_case_q, ign_case_d;
  logic [ADDR_W-1:0] base_q, base_d;

  // Region offset of the next byte
  logic [ADDR_W-1:0] offset_q, offset_d;

  logic       in_acc;
  logic       out_full;
  cell_ctrl_t ctrl;
  cell_data_t chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] pos_ok;
  logic       len_ok;
  logic       hit;
  res_t       res_new;
  res_t       res_out;

  // ---------------------------------------------------------------- config
  always_comb begin
    pattern_d  = pattern_q;
    len_d      = len_q;
    ign_case_d = ign_case_q;
    base_d     = base_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_LOW:  pattern_d[63:0]   = cfg_data_i;
        CFG_PAT_HIGH: pattern_d[127:64] = cfg_data_i;
        CFG_PAT_LEN:  len_d             = cfg_data_i[LEN_W-1:0];
        CFG_IGN_CASE: ign_case_d        = cfg_data_i[0];
        CFG_BASE:     base_d            = cfg_data_i;
        default: ;    // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      len_q      <= LEN_W'(1);
      ign_case_q <= 1'b0;
      base_q     <= '0;
    end else begin
      pattern_q  <= pattern_d;
      len_q      <= len_d;
      ign_case_q <= ign_case_d;
      base_q     <= base_d;
    end
  end

  // ---------------------------------------------------------------- window
  assign in_stall_o = out_full;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctrl.shift = in_acc;
  assign ctrl.clear = region_end_i;
  assign ctrl.fold  = ign_case_q;

  // The new byte enters at the head of the chain, always held.
  assign chain[0].held = 1'b1;
  assign chain[0].data = data_byte_i;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    localparam logic [6:0] CELL_IDX = 7'(i);
    logic [6:0] pat_idx;
    logic [7:0] pat_byte;

    // Cell i holds the byte that lines up with pattern byte len-1-i.
    // Pattern positions beyond the sixteen configured bytes read as zero.
    assign pat_idx  = {2'b00, len_q} - 7'd1 - CELL_IDX;
    assign pat_byte = (pat_idx[6:4] == 3'b000) ? pattern_q[{pat_idx[3:0], 3'b000} +: 8]
                                               : 8'h00;

    bps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_i     (chain[i]),
      .pat_byte_i (pat_byte),
      .cell_o     (chain[i+1]),
      .eq_o       (eq[i])
    );

    // Positions past the pattern length do not take part.
    assign pos_ok[i] = eq[i] || !({2'b00, len_q} > CELL_IDX);
  end

  // A zero or overlong length never matches. The held flags inside eq make
  // sure the window already holds at least len bytes.
  assign len_ok = (len_q != '0) && ({2'b00, len_q} <= MAX_LEN);
  assign hit    = len_ok && (&pos_ok);

  // ---------------------------------------------------------------- offset
  always_comb begin
    offset_d = offset_q;
    if (in_acc) begin
      offset_d = region_end_i ? '0 : offset_q + 64'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else begin
      offset_q <= offset_d;
    end
  end

  // ---------------------------------------------------------------- result
  assign res_new.found = hit;
  assign res_new.addr  = hit ? base_q + offset_q - (64'(len_q) - 64'd1) : '0;
  assign res_new.done  = region_end_i;

  bps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && (hit || region_end_i)),
    .res_i       (res_new),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .full_o      (out_full)
  );

  assign found_o         = res_out.found;
  assign match_address_o = res_out.addr;
  assign scan_done_o     = res_out.done;

`ifndef SYNTHESIS
  // Every delivered word carries a match or a region end.
  a_word_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o || scan_done_o))
    else $error("output word with neither found nor scan_done");

  // Address reads zero unless a match is reported.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (match_address_o == '0))
    else $error("match address nonzero without a match");

  // A region end empties the whole window and resets the offset.
  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && region_end_i) |=> (!chain[1].held && !chain[MAX_PATTERN].held &&
                                  (offset_q == '0)))
    else $error("window or offset not cleared after region end");

  // Input stalls only while the skid word backs up a held result.
  a_stall_has_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");
`endif

endmodule

// File: design/bps_cell.sv
// ----------------------------------------------------------------------------
// bps_cell: one window position
// Holds one byte and its held flag, shifts them on, and compares the
// incoming byte against this position's pattern byte.
// ----------------------------------------------------------------------------
module bps_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bps_pkg::cell_ctrl_t ctrl_i,
  input  bps_pkg::cell_data_t prev_i,
  input  logic [7:0]         pat_byte_i,
  output bps_pkg::cell_data_t cell_o,
  output logic               eq_o
);
  import bps_pkg::*;

  logic       held_q, held_d;
  logic [7:0] data_q, data_d;

  // Compare against the byte this cell is about to take.
  assign eq_o = prev_i.held &&
                (fold_byte(prev_i.data, ctrl_i.fold) == fold_byte(pat_byte_i, ctrl_i.fold));

  always_comb begin
    held_d = held_q;
    data_d = data_q;
    if (ctrl_i.shift) begin
      held_d = prev_i.held && !ctrl_i.clear;
      data_d = prev_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o.held = held_q;
  assign cell_o.data = data_q;

endmodule

// File: design/bps_out_buf.sv
// ----------------------------------------------------------------------------
// bps_out_buf: result register with skid stage
// Holds results for the output channel; a skid word catches one result while
// the output register is stalled.
// ----------------------------------------------------------------------------
module bps_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bps_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output bps_pkg::res_t res_o,
  output logic          full_o
);
  import bps_pkg::*;

  logic o_valid_q, o_valid_d;
  logic s_valid_q, s_valid_d;
  res_t o_q, o_d;
  res_t s_q, s_d;

  always_comb begin
    o_valid_d = o_valid_q;
    s_valid_d = s_valid_q;
    o_d       = o_q;
    s_d       = s_q;
    if (!o_valid_q || !out_stall_i) begin
      if (s_valid_q) begin
        // drain the skid word first
        o_d       = s_q;
        o_valid_d = 1'b1;
        s_valid_d = 1'b0;
      end else begin
        o_d       = res_i;
        o_valid_d = push_i;
      end
    end else if (push_i) begin
      s_d       = res_i;
      s_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q <= o_d;
    s_q <= s_d;
  end

  assign out_valid_o = o_valid_q;
  assign res_o       = o_q;
  assign full_o      = s_valid_q;

endmodule

// File: tb/scan_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// scan_scoreboard_pkg: match prediction and result checking for the scan core
// Tracks the register file, the byte window and the region offset, predicts
// the match and done words for every accepted byte and compares the output.
// ----------------------------------------------------------------------------
package scan_scoreboard_pkg;
  import bps_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned MAX_LOGGED   = 40;

  class match_scoreboard;
    logic [63:0]       pat_low;
    logic [63:0]       pat_high;
    logic [LEN_W-1:0]  pat_len;
    logic              fold_en;
    logic [ADDR_W-1:0] base_addr;
    logic [7:0]        window [WINDOW_DEPTH];
    int unsigned       held;
    logic [ADDR_W-1:0] offset;
    res_t              pending_q [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      pat_low   = '0;
      pat_high  = '0;
      pat_len   = LEN_W'(1);
      fold_en   = 1'b0;
      base_addr = '0;
      errors    = 0;
      checked   = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (window[i]) window[i] = 8'h00;
      held   = 0;
      offset = '0;
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      if (fold_en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return c + CASE_OFFSET;
      return c;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PAT_LOW:  pat_low   = val;
        CFG_PAT_HIGH: pat_high  = val;
        CFG_PAT_LEN:  pat_len   = val[LEN_W-1:0];
        CFG_IGN_CASE: fold_en   = val[0];
        CFG_BASE:     base_addr = val;
        default: ;
      endcase
    endfunction

    // Shift the byte in, compare the window and queue any word it causes.
    function void note_byte(logic [7:0] b, logic last);
      logic [PAT_W-1:0] pat;
      int unsigned      len;
      logic             hit;
      res_t             r;
      pat = {pat_high, pat_low};
      len = pat_len;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (held < WINDOW_DEPTH) held++;
      hit = 1'b0;
      if (len >= 1 && len <= WINDOW_DEPTH && held >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (lower(pat[8*i +: 8]) != lower(window[len-1-i])) hit = 1'b0;
        end
      end
      r.found = hit;
      r.addr  = hit ? base_addr + offset - ADDR_W'(len - 1) : '0;
      r.done  = last;
      offset++;
      if (last) clear_window();
      if (hit || last) pending_q = {pending_q, r};
    endfunction

    task flag_mismatch(string msg);
      errors++;
      // keep the log short on a badly broken build
      if (errors <= MAX_LOGGED) $display("scan mismatch at word %0d: %s", checked, msg);
    endtask

    task check_result(logic f, logic [ADDR_W-1:0] a, logic d);
      res_t want;
      checked++;
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word found=%0b addr=%h done=%0b", f, a, d));
        return;
      end
      want = pending_q.pop_front();
      if (f !== want.found)
        flag_mismatch($sformatf("found %0b, want %0b", f, want.found));
      if (a !== want.addr)
        flag_mismatch($sformatf("match_address %h, want %h", a, want.addr));
      if (d !== want.done)
        flag_mismatch($sformatf("scan_done %0b, want %0b", d, want.done));
    endtask
  endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for byte_pattern_scan_core
// Drives region bytes through the valid/stall handshake under random idling,
// programs the pattern registers between phases and checks every output word
// against a scoreboard that mirrors the window search.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;
  import scan_scoreboard_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1700;
  localparam int unsigned FINAL_ITEMS   = 200;
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam int unsigned HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;     // covers a byte that yields no word
  localparam int unsigned IDX_SPAN      = 1 << CFG_IDX_W;
  localparam int unsigned PRESSURE_AT   = 3;     // phase that carries the hold-off

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i  = 8'h00;
  logic                  region_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  found_o;
  logic [ADDR_W-1:0]     match_address_o;
  logic                  scan_done_o;

  // receiver controls, written by the stimulus at clock edges
  logic        rx_idle_en = 1'b0;
  int unsigned hold_reqs  = 0;
  // hold-offs already served, owned by the receiver
  int unsigned holds_done = 0;

  // sender state, owned by the stimulus process
  bit               tx_idle_en = 1'b0;
  int unsigned      items_sent = 0;
  logic [7:0]       pat_bytes [WINDOW_DEPTH];
  logic [LEN_W-1:0] cur_len    = LEN_W'(1);
  logic             cur_fold   = 1'b0;

  match_scoreboard sb = new();

  byte_pattern_scan_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .region_end_i    (region_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .match_address_o (match_address_o),
    .scan_done_o     (scan_done_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitor both channels on the edge. Note the input word before checking the
  // output so a same-cycle word would still find its expectation. The watchdog
  // ends the run once the quiet count reaches STALL_LIMIT.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_byte(data_byte_i, region_end_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(found_o, match_address_o, scan_done_o);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: hold off for a long stretch on request, otherwise stall in short
  // random bursts while idling is enabled.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        holds_done++;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one word and hold it until accepted; maybe idle first.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    region_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid, let the monitor note the last byte, wait for every expected
  // word, then let a trailing byte settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [LEN_W-1:0] len, input logic ign,
                              input logic [ADDR_W-1:0] base);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_HIGH, hi);
    // upper data bits are don't-care for the narrow registers
    write_reg(CFG_PAT_LEN, {noise[63:LEN_W], len});
    write_reg(CFG_IGN_CASE, {noise[63:1], ign});
    write_reg(CFG_BASE, base);
    // a write to an unused index must leave every register alone
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_BASE + 1, IDX_SPAN - 1)), {$urandom, $urandom});
    end
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      pat_bytes[i]     = lo[8*i +: 8];
      pat_bytes[i + 8] = hi[8*i +: 8];
    end
    cur_len  = len;
    cur_fold = ign;
  endtask

  function automatic bit is_letter(logic [7:0] c);
    logic [7:0] up;
    up = c & ~CASE_OFFSET;
    return up >= ASCII_UPPER_A && up <= ASCII_UPPER_Z;
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    return is_letter(c) ? c ^ CASE_OFFSET : c;
  endfunction

  // Bias pattern bytes toward letters so case folding gets real work.
  function automatic logic [7:0] pick_pattern_byte();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = 8'h00;
      1: c = 8'hFF;
      2, 3, 4: begin
        c = ASCII_UPPER_A + 8'($urandom_range(0, ASCII_UPPER_Z - ASCII_UPPER_A));
        if ($urandom_range(0, 1) == 1) c = c | CASE_OFFSET;
      end
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  task automatic randomize_config();
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] base;
    int unsigned       pick;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_pattern_byte();
      hi[8*i +: 8] = pick_pattern_byte();
    end
    // mostly short patterns, now and then full width, zero or overlong
    pick = $urandom_range(0, 19);
    if (pick < 10)      len = LEN_W'($urandom_range(1, 4));
    else if (pick < 15) len = LEN_W'($urandom_range(5, WINDOW_DEPTH - 1));
    else if (pick < 17) len = LEN_W'(WINDOW_DEPTH);
    else if (pick < 18) len = '0;
    else                len = LEN_W'($urandom_range(WINDOW_DEPTH + 1, (1 << LEN_W) - 1));
    case ($urandom_range(0, 5))
      0:       base = '0;
      1:       base = '1;
      2:       base = '1 - ADDR_W'($urandom_range(0, 40));  // wraps inside a region
      default: base = {$urandom, $urandom};
    endcase
    apply_config(lo, hi, len, 1'($urandom_range(0, 1)), base);
  endtask

  // Mostly whole or case-flipped copies of the pattern in a stream of pattern
  // bytes and noise; some copies are cut short. Regions end at random.
  task automatic run_phase(input int unsigned n_items);
    logic [7:0]  copy_q [$];
    logic [7:0]  b;
    int unsigned span;
    for (int k = 0; k < n_items; k++) begin
      if (copy_q.size() == 0 && $urandom_range(0, 2) == 0) begin
        span = (cur_len >= 1 && cur_len <= WINDOW_DEPTH) ? cur_len
                                                         : $urandom_range(1, WINDOW_DEPTH);
        if ($urandom_range(0, 4) == 0) span = $urandom_range(1, span);
        for (int i = 0; i < span; i++) begin
          b = pat_bytes[i];
          if ($urandom_range(0, 9) < (cur_fold ? 5 : 1)) b = flip_case(b);
          copy_q = {copy_q, b};
        end
      end
      if (copy_q.size() != 0) begin
        b = copy_q.pop_front();
      end else if ($urandom_range(0, 1) == 1) begin
        b = pat_bytes[$urandom_range(0, WINDOW_DEPTH - 1)];
        if ($urandom_range(0, 1) == 1) b = flip_case(b);
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, $urandom_range(0, 29) == 0);
    end
  endtask

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    int unsigned phase;

    foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: a one-byte pattern of zero at base zero.
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();

    // Case-insensitive two-byte pattern "Ab" at the top of the address space:
    // the second match wraps its address around zero.
    apply_config(64'h0000_0000_0000_6241, '0, LEN_W'(2), 1'b1, '1);
    send_byte(8'h61, 1'b0);  // a
    send_byte(8'h42, 1'b0);  // B
    send_byte(8'h40, 1'b0);  // just below the upper-case range
    send_byte(8'h41, 1'b0);  // A
    send_byte(8'h62, 1'b1);  // b
    wait_idle();

    // Full sixteen-byte pattern: a region too short for it, then an exact hit
    // on the region's final byte.
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    apply_config(lo, hi, LEN_W'(WINDOW_DEPTH), 1'b0, {$urandom, $urandom});
    send_byte(pat_bytes[0], 1'b0);
    send_byte(pat_bytes[1], 1'b1);
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      send_byte(pat_bytes[i], i == WINDOW_DEPTH - 1);
    end
    wait_idle();

    // Zero and overlong lengths never match.
    apply_config(lo, hi, '0, 1'b0, '0);
    send_byte(pat_bytes[0], 1'b1);
    wait_idle();
    apply_config(lo, hi, '1, 1'b0, '0);
    send_byte(pat_bytes[0], 1'b1);

    // Random phases. Regions may run across a phase boundary, so a new
    // setting meets a window already holding bytes.
    phase = 0;
    while (items_sent < ITEM_TARGET - FINAL_ITEMS) begin
      wait_idle();
      if (phase == PRESSURE_AT) begin
        // Every byte matches while the receiver holds off, so the output
        // fills and the input has to stall.
        apply_config(64'h0000_0000_0000_005A, {$urandom, $urandom}, LEN_W'(1), 1'b0,
                     {$urandom, $urandom});
        tx_idle_en = 1'b0;
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < 48; i++) send_byte(8'h5A, i == 47);
        wait_idle();
      end
      randomize_config();
      tx_idle_en = $urandom_range(0, 9) < 7;
      rx_idle_en <= ($urandom_range(0, 9) < 7);
      run_phase($urandom_range(40, 140));
      phase++;
    end

    // Closing stretch at full rate on both sides.
    wait_idle();
    randomize_config();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    run_phase(FINAL_ITEMS);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bps_pkg.sv
design/bps_cell.sv
design/bps_out_buf.sv
design/byte_pattern_scan_core.sv
tb/scan_scoreboard_pkg.sv
tb/tb_top.sv
